FILE: src/arch_conditional_variance_core_assert.svh
// Assertion macros shared by the conditional variance core.
// Each macro expects clk_i and rst_ni to exist in the module that uses it.
`ifndef ARCH_CONDITIONAL_VARIANCE_CORE_ASSERT_SVH
`define ARCH_CONDITIONAL_VARIANCE_CORE_ASSERT_SVH

// Same-cycle implication.
`define ACV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ACV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/acv_pkg.sv
package acv_pkg;

  localparam int unsigned VarW    = 32;
  localparam int unsigned WeightW = 16;
  localparam int unsigned ResW    = 16;
  localparam int unsigned OrderW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NumWeights = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_BASE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_W1    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_W2    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_W3    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_W4    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ORDER = 3'd5;

  localparam logic [OrderW-1:0] OrderReset = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_e;

  // Controls driven from the sequencer into the row of cells.
  typedef struct packed {
    logic accept;  // input transfer this cycle
    logic clear;   // empty the history (restart)
    logic shift;   // form products and push the new square
  } ctrl_t;

endpackage

FILE: src/acv_cell.sv
module acv_cell import acv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  input  logic               active_i,
  input  logic [WeightW-1:0] weight_i,
  input  logic [VarW-1:0]    sq_i,
  input  logic               vld_i,
  input  logic [VarW-1:0]    psum_i,
  input  logic               psat_i,
  output logic [VarW-1:0]    sq_o,
  output logic               vld_o,
  output logic [VarW-1:0]    psum_o,
  output logic               psat_o
);

  logic [VarW-1:0]         sq_q, sq_d;
  logic                    vld_q, vld_d;
  logic [VarW+WeightW-1:0] prod_full;
  logic [VarW-1:0]         prod_q, prod_d;
  logic [VarW:0]           sum;
  logic [VarW-1:0]         psum_q, psum_d;
  logic                    psat_q, psat_d;

  // History entry and its seen flag move one cell down on every push.
  always_comb begin
    sq_d  = sq_q;
    vld_d = vld_q;
    if (ctrl_i.clear) begin
      sq_d  = '0;
      vld_d = 1'b0;
    end else if (ctrl_i.shift) begin
      sq_d  = sq_i;
      vld_d = vld_i;
    end
  end

  assign prod_full = VarW'(0) + (weight_i * sq_q);
  assign prod_d    = (active_i && vld_q) ? prod_full[VarW+WeightW-1:WeightW] : '0;

  // Saturating partial sum, handed to the next cell every cycle.
  assign sum    = {1'b0, psum_i} + {1'b0, prod_q};
  assign psat_d = psat_i | sum[VarW];
  assign psum_d = psat_d ? '1 : sum[VarW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q  <= '0;
      vld_q <= 1'b0;
    end else begin
      sq_q  <= sq_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      prod_q <= prod_d;
    end
    psum_q <= psum_d;
    psat_q <= psat_d;
  end

  assign sq_o   = sq_q;
  assign vld_o  = vld_q;
  assign psum_o = psum_q;
  assign psat_o = psat_q;

endmodule

FILE: src/acv_ctrl.sv
`include "arch_conditional_variance_core_assert.svh"

module acv_ctrl import acv_pkg::*; #(
  parameter int unsigned MAX_LAGS = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  restart_i,
  input  logic  out_stall_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  output ctrl_t ctrl_o
);

  localparam int unsigned CntW = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_LAGS - 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            accept;

  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_ACC;
        cnt_d   = '0;
      end
      ST_ACC: begin
        if (cnt_q == CntLast) begin
          state_d = ST_OUT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != ST_IDLE);
    out_valid_o   = (state_q == ST_OUT);
    ctrl_o.accept = accept;
    ctrl_o.clear  = accept && restart_i;
    ctrl_o.shift  = (state_q == ST_MUL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `ACV_ASSERT_NOW(a_no_accept_with_result, out_valid_o, in_stall_o, "input taken while a result waits")
  `ACV_ASSERT_NEXT(a_accept_then_shift, ctrl_o.accept, ctrl_o.shift, "push did not follow the input transfer")
  `ACV_ASSERT_NEXT(a_single_shift, ctrl_o.shift, !ctrl_o.shift, "history pushed twice for one item")
  `ACV_ASSERT_NOW(a_result_after_sum, $rose(out_valid_o), $past(state_q == ST_ACC), "result offered before the sum chain settled")

endmodule

FILE: src/arch_conditional_variance_core.sv
// ARCH(p) conditional variance core. Each input transfer carries one residual
// (signed Q4.12) and a restart flag; the block answers with one result
// transfer holding base_variance plus, for every lag k up to the model
// order, lag_weight_k times the squared residual k dates back (Q8.24,
// products truncated), saturated at all ones with the saturated flag set.
// A restart empties the history before the sum is formed. Only one item is
// in flight: its input transfer is followed by the push of the history, the
// ripple of the partial sum through the row of MAX_LAGS cells, one cell per
// cycle, and the offer of the result; the next item is taken in the cycle
// after the result transfer.
// Configuration registers may be written only while no item is in flight.

module arch_conditional_variance_core import acv_pkg::*; #(
  parameter int unsigned MAX_LAGS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [VarW-1:0]    cfg_wdata_i,
  // Input channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ResW-1:0]    residual_i,
  input  logic               restart_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [VarW-1:0]    variance_o,
  output logic               saturated_o
);

  // Configuration registers.
  logic [VarW-1:0]    base_q;
  logic [WeightW-1:0] weight_q [NumWeights];
  logic [OrderW-1:0]  order_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      weight_q <= '{default: '0};
      order_q  <= OrderReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE:  base_q      <= cfg_wdata_i;
        REG_W1:    weight_q[0] <= cfg_wdata_i[WeightW-1:0];
        REG_W2:    weight_q[1] <= cfg_wdata_i[WeightW-1:0];
        REG_W3:    weight_q[2] <= cfg_wdata_i[WeightW-1:0];
        REG_W4:    weight_q[3] <= cfg_wdata_i[WeightW-1:0];
        REG_ORDER: order_q     <= cfg_wdata_i[OrderW-1:0];
        default: ;  // writes to unknown indexes are dropped
      endcase
    end
  end

  // Sequencer: one item at a time through accept, push, ripple and offer.
  ctrl_t ctrl;

  acv_ctrl #(
    .MAX_LAGS (MAX_LAGS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .restart_i   (restart_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .ctrl_o      (ctrl)
  );

  // The square of the incoming residual is formed on the input transfer and
  // enters the head of the row when the history is pushed. The magnitude is
  // formed in seventeen bits so that negating the most negative residual
  // cannot overflow, and its square (at most 2^30) fits in 32 bits.
  logic signed [ResW:0]  res_ext;
  logic        [ResW:0]  mag;
  logic        [2*ResW+1:0] sq_full;
  logic        [VarW-1:0] sq_new_q;

  assign res_ext = {residual_i[ResW-1], residual_i};
  assign mag     = res_ext[ResW] ? (ResW+1)'(-res_ext) : res_ext;
  assign sq_full = mag * mag;

  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      sq_new_q <= sq_full[VarW-1:0];
    end
  end

  // Row of cells. Cell k forms the product for lag k+1 from the square it
  // held before the push; the partial sum enters with the base term and
  // gains one product per cell per cycle, so the full sum stands at the last
  // cell once it has passed the sum register of every cell.
  logic [VarW-1:0] sq_chain   [MAX_LAGS+1];
  logic            vld_chain  [MAX_LAGS+1];
  logic [VarW-1:0] psum_chain [MAX_LAGS+1];
  logic            psat_chain [MAX_LAGS+1];

  assign sq_chain[0]   = sq_new_q;
  assign vld_chain[0]  = 1'b1;
  assign psum_chain[0] = base_q;
  assign psat_chain[0] = 1'b0;

  for (genvar k = 0; k < MAX_LAGS; k++) begin : g_cell
    logic [WeightW-1:0] weight;
    logic               active;

    // Lags beyond the weight registers carry a weight of zero.
    if (k < NumWeights) begin : g_w
      assign weight = weight_q[k];
    end else begin : g_nw
      assign weight = '0;
    end

    // An order above MAX_LAGS simply enables every cell.
    assign active = (32'(order_q) > 32'(k));

    acv_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .active_i (active),
      .weight_i (weight),
      .sq_i     (sq_chain[k]),
      .vld_i    (vld_chain[k]),
      .psum_i   (psum_chain[k]),
      .psat_i   (psat_chain[k]),
      .sq_o     (sq_chain[k+1]),
      .vld_o    (vld_chain[k+1]),
      .psum_o   (psum_chain[k+1]),
      .psat_o   (psat_chain[k+1])
    );
  end

  // The sum chain holds steady while the result waits, since the products
  // and the base term do not change until the next push.
  assign variance_o  = psum_chain[MAX_LAGS];
  assign saturated_o = psat_chain[MAX_LAGS];

endmodule
